@@ hw/rtl/casu_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the cursor list unit.
package casu_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 64;
  localparam int FUNC_W   = 4;
  localparam int IDX_W    = 5;
  localparam int STAT_W   = 2;
  // Address width (positions and RAM addresses), count width (0..CAPACITY)
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // Width for comparing read_index against the count
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] F_START        = 4'd0;
  localparam logic [FUNC_W-1:0] F_END          = 4'd1;
  localparam logic [FUNC_W-1:0] F_LAST         = 4'd2;
  localparam logic [FUNC_W-1:0] F_ADVANCE      = 4'd3;
  localparam logic [FUNC_W-1:0] F_RETREAT      = 4'd4;
  localparam logic [FUNC_W-1:0] F_INSERT       = 4'd5;
  localparam logic [FUNC_W-1:0] F_ATTACH       = 4'd6;
  localparam logic [FUNC_W-1:0] F_REMOVE       = 4'd7;
  localparam logic [FUNC_W-1:0] F_INSERT_FRONT = 4'd8;
  localparam logic [FUNC_W-1:0] F_ATTACH_BACK  = 4'd9;
  localparam logic [FUNC_W-1:0] F_REMOVE_FRONT = 4'd10;
  localparam logic [FUNC_W-1:0] F_READ         = 4'd11;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOCUR = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_INS,
    SHIFT_REM
  } shift_t;

  typedef enum logic [2:0] {
    RAM_IDLE,
    RAM_SRC_RD,
    RAM_SHIFT_WR,
    RAM_PUT,
    RAM_IDX_RD,
    RAM_CUR_RD
  } ram_op_t;

  typedef struct packed {
    logic    load;
    ram_op_t ram_op;
    logic    cap_rd;
    logic    cap_cur;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    shift_t kind;
    logic   more;
    logic   want_idx;
  } sts_t;

endpackage

@@ hw/rtl/casu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module casu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/casu_ctrl.sv @@
// Sequencer for the cursor list unit: shift sweeps, reads and result hand-off.
module casu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  casu_pkg::sts_t sts,
  output casu_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_PUT,
    S_RD_IDX,
    S_RD_IDX_CAP,
    S_RD_CUR,
    S_RD_CUR_CAP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.ram_op  = casu_pkg::RAM_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        case (sts.kind)
          casu_pkg::SHIFT_INS: state_nxt = sts.more ? S_SWEEP_RD : S_PUT;
          casu_pkg::SHIFT_REM: state_nxt = sts.more ? S_SWEEP_RD : S_RD_CUR;
          default:             state_nxt = sts.want_idx ? S_RD_IDX : S_RD_CUR;
        endcase
      end
      S_SWEEP_RD: begin
        cmd.ram_op = casu_pkg::RAM_SRC_RD;
        state_nxt  = S_SWEEP_WR;
      end
      S_SWEEP_WR: begin
        cmd.ram_op = casu_pkg::RAM_SHIFT_WR;
        state_nxt  = S_PLAN;
      end
      S_PUT: begin
        cmd.ram_op = casu_pkg::RAM_PUT;
        state_nxt  = S_RD_CUR;
      end
      S_RD_IDX: begin
        cmd.ram_op = casu_pkg::RAM_IDX_RD;
        state_nxt  = S_RD_IDX_CAP;
      end
      S_RD_IDX_CAP: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_RD_CUR;
      end
      S_RD_CUR: begin
        cmd.ram_op = casu_pkg::RAM_CUR_RD;
        state_nxt  = S_RD_CUR_CAP;
      end
      S_RD_CUR_CAP: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/casu_dp.sv @@
// Datapath for the cursor list unit: count, cursor, operation plan, entry RAM, result registers.
module casu_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  casu_pkg::cmd_t                cmd,
  output casu_pkg::sts_t                sts,
  input  logic [casu_pkg::FUNC_W-1:0]   in_func,
  input  logic [casu_pkg::DATA_W-1:0]   in_entry_value,
  input  logic [casu_pkg::IDX_W-1:0]    in_read_index,
  output logic [casu_pkg::STAT_W-1:0]   out_status,
  output logic                          out_has_current,
  output logic [casu_pkg::DATA_W-1:0]   out_current_value,
  output logic [casu_pkg::CW-1:0]       out_entry_count,
  output logic [casu_pkg::DATA_W-1:0]   out_read_value
);

  localparam int AW = casu_pkg::AW;
  localparam int CW = casu_pkg::CW;
  localparam int XW = casu_pkg::XW;
  localparam logic [CW-1:0] LAST_POS = CW'(casu_pkg::CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(casu_pkg::CAPACITY);

  // Control state; the cursor may sit one past the top slot after an append that fills the list
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          cursor_r, cursor_nxt;
  casu_pkg::shift_t       kind_r, kind_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  // Payload
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [casu_pkg::DATA_W-1:0] val_r;
  logic [AW-1:0]          idx_addr_r;
  logic                   want_idx_r, want_idx_nxt;
  logic [casu_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [casu_pkg::DATA_W-1:0] rd_val_r, cur_val_r;
  logic [casu_pkg::STAT_W-1:0] out_status_r;
  logic                   out_has_cur_r;
  logic [casu_pkg::DATA_W-1:0] out_cur_val_r, out_rd_val_r;
  logic [CW-1:0]          out_count_r;

  logic                   cur, full;
  logic [XW-1:0]          idx_x;
  logic                   has_cur;

  // RAM port
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [casu_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

  assign cur     = cursor_r < count_r;
  assign full    = (count_r == FULL_CNT);
  assign idx_x   = XW'(in_read_index);
  assign has_cur = cur;

  // Plan the operation at accept
  always_comb begin
    status_nxt   = casu_pkg::ST_OK;
    cursor_nxt   = cursor_r;
    kind_nxt     = casu_pkg::SHIFT_NONE;
    pos_nxt      = '0;
    want_idx_nxt = 1'b0;
    case (in_func)
      casu_pkg::F_START: cursor_nxt = '0;
      casu_pkg::F_END: begin
        cursor_nxt = (count_r == '0) ? '0 : count_r - CW'(1);
      end
      casu_pkg::F_LAST: cursor_nxt = LAST_POS;
      casu_pkg::F_ADVANCE: begin
        if (!cur) begin
          status_nxt = casu_pkg::ST_NOCUR;
        end else if (cursor_r < LAST_POS) begin
          cursor_nxt = cursor_r + CW'(1);
        end
      end
      casu_pkg::F_RETREAT: begin
        if (cursor_r != '0) begin
          cursor_nxt = cursor_r - CW'(1);
        end
      end
      casu_pkg::F_INSERT: begin
        if (full) begin
          status_nxt = casu_pkg::ST_FULL;
        end else if (!cur) begin
          kind_nxt   = casu_pkg::SHIFT_INS;
          cursor_nxt = '0;
        end else begin
          kind_nxt = casu_pkg::SHIFT_INS;
          pos_nxt  = cursor_r[AW-1:0];
        end
      end
      casu_pkg::F_ATTACH: begin
        if (full) begin
          status_nxt = casu_pkg::ST_FULL;
        end else if (count_r == '0) begin
          kind_nxt   = casu_pkg::SHIFT_INS;
          cursor_nxt = '0;
        end else if (!cur) begin
          kind_nxt   = casu_pkg::SHIFT_INS;
          pos_nxt    = AW'(count_r);
          cursor_nxt = count_r;
        end else begin
          kind_nxt   = casu_pkg::SHIFT_INS;
          pos_nxt    = cursor_r[AW-1:0] + AW'(1);
          cursor_nxt = cursor_r + CW'(1);
        end
      end
      casu_pkg::F_REMOVE: begin
        if (!cur) begin
          status_nxt = casu_pkg::ST_NOCUR;
        end else begin
          kind_nxt = casu_pkg::SHIFT_REM;
          pos_nxt  = cursor_r[AW-1:0];
        end
      end
      casu_pkg::F_INSERT_FRONT: begin
        if (full) begin
          status_nxt = casu_pkg::ST_FULL;
        end else begin
          kind_nxt   = casu_pkg::SHIFT_INS;
          cursor_nxt = '0;
        end
      end
      casu_pkg::F_ATTACH_BACK: begin
        // Park the cursor on the new count: no current item afterwards
        if (full) begin
          status_nxt = casu_pkg::ST_FULL;
        end else begin
          kind_nxt   = casu_pkg::SHIFT_INS;
          pos_nxt    = AW'(count_r);
          cursor_nxt = count_r + CW'(1);
        end
      end
      casu_pkg::F_REMOVE_FRONT: begin
        if (count_r == '0) begin
          status_nxt = casu_pkg::ST_NOCUR;
        end else begin
          kind_nxt   = casu_pkg::SHIFT_REM;
          cursor_nxt = '0;
        end
      end
      casu_pkg::F_READ: begin
        if (idx_x < XW'(count_r)) begin
          want_idx_nxt = 1'b1;
        end else begin
          status_nxt = casu_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  // Count and sweep pointer
  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    if (cmd.load) begin
      case (kind_nxt)
        casu_pkg::SHIFT_INS: begin
          count_nxt = count_r + CW'(1);
          ptr_nxt   = AW'(count_r);
        end
        casu_pkg::SHIFT_REM: begin
          count_nxt = count_r - CW'(1);
          ptr_nxt   = pos_nxt;
        end
        default: ;
      endcase
    end else if (cmd.ram_op == casu_pkg::RAM_SHIFT_WR) begin
      ptr_nxt = (kind_r == casu_pkg::SHIFT_INS) ? ptr_r - AW'(1) : ptr_r + AW'(1);
    end
  end

  // Sweep continues while entries above the hole (insert) or below the new end (remove) remain
  always_comb begin
    sts.kind     = kind_r;
    sts.want_idx = want_idx_r;
    case (kind_r)
      casu_pkg::SHIFT_INS: sts.more = ptr_r > pos_r;
      casu_pkg::SHIFT_REM: sts.more = {{(CW-AW){1'b0}}, ptr_r} < count_r;
      default:             sts.more = 1'b0;
    endcase
  end

  // RAM addressing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = ram_rdata;
    ram_raddr = cursor_r[AW-1:0];
    case (cmd.ram_op)
      casu_pkg::RAM_SRC_RD: begin
        ram_raddr = (kind_r == casu_pkg::SHIFT_INS) ? ptr_r - AW'(1) : ptr_r + AW'(1);
      end
      casu_pkg::RAM_SHIFT_WR: ram_we = 1'b1;
      casu_pkg::RAM_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
      end
      casu_pkg::RAM_IDX_RD: ram_raddr = idx_addr_r;
      casu_pkg::RAM_CUR_RD: ram_raddr = cursor_r[AW-1:0];
      default: ;
    endcase
  end

  casu_ram #(
    .WIDTH (casu_pkg::DATA_W),
    .DEPTH (casu_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
      kind_r   <= casu_pkg::SHIFT_NONE;
      ptr_r    <= '0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      if (cmd.load) begin
        cursor_r <= cursor_nxt;
        kind_r   <= kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r      <= pos_nxt;
      val_r      <= in_entry_value;
      idx_addr_r <= idx_x[AW-1:0];
      want_idx_r <= want_idx_nxt;
      status_r   <= status_nxt;
      rd_val_r   <= '0;
    end else if (cmd.cap_rd) begin
      rd_val_r <= ram_rdata;
    end
    if (cmd.cap_cur) begin
      cur_val_r <= has_cur ? ram_rdata : '0;
    end
    if (cmd.emit) begin
      out_status_r  <= status_r;
      out_has_cur_r <= has_cur;
      out_cur_val_r <= cur_val_r;
      out_count_r   <= count_r;
      out_rd_val_r  <= rd_val_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_has_current   = out_has_cur_r;
  assign out_current_value = out_cur_val_r;
  assign out_entry_count   = out_count_r;
  assign out_read_value    = out_rd_val_r;

endmodule

@@ hw/rtl/cursor_array_sequence_unit.sv @@
// Steps from accept to result: plan, then any shift sweep, the write of the new entry for an
//   insert, the indexed read for a read, the current-entry read, then the result hand-off.
// Throughput: one item at a time, the next beat taken only after the result registers;
//   each shifted entry costs three steps (plan, read, write).
// The output register holds a finished beat while the next item is accepted and worked on.
// Reset (rst_n, synchronous, active low) empties the list and zeroes the cursor; RAM not cleared.
module cursor_array_sequence_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [casu_pkg::FUNC_W-1:0]   in_func,
  input  logic [casu_pkg::DATA_W-1:0]   in_entry_value,
  input  logic [casu_pkg::IDX_W-1:0]    in_read_index,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [casu_pkg::STAT_W-1:0]   out_status,
  output logic                          out_has_current,
  output logic [casu_pkg::DATA_W-1:0]   out_current_value,
  output logic [casu_pkg::CW-1:0]       out_entry_count,
  output logic [casu_pkg::DATA_W-1:0]   out_read_value
);

  // Commands flow from the sequencer to the datapath; status flows back.
  casu_pkg::cmd_t cmd;
  casu_pkg::sts_t sts;

  // Sequencer: accept a beat when idle, walk the shift sweep, then read
  // back the indexed and current entries and hand the result to the
  // output register once it is free.
  casu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: plan the operation against count and cursor at accept,
  // shift entries in the RAM one at a time, hold the result fields.
  casu_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_entry_value    (in_entry_value),
    .in_read_index     (in_read_index),
    .out_status        (out_status),
    .out_has_current   (out_has_current),
    .out_current_value (out_current_value),
    .out_entry_count   (out_entry_count),
    .out_read_value    (out_read_value)
  );

endmodule

@@ tb/sv/cursor_list_checker.sv @@
// Checker for the cursor list unit: predicts each result beat and compares it with the block.
`timescale 1ns / 1ps

module cursor_list_checker
  import casu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [DATA_W-1:0] in_entry_value,
  input  logic [IDX_W-1:0]  in_read_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [STAT_W-1:0] out_status,
  input  logic              out_has_current,
  input  logic [DATA_W-1:0] out_current_value,
  input  logic [CW-1:0]     out_entry_count,
  input  logic [DATA_W-1:0] out_read_value,
  output int                mismatches,
  output int                beats_due
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              has_current;
    logic [DATA_W-1:0] current_value;
    logic [CW-1:0]     entry_count;
    logic [DATA_W-1:0] read_value;
  } list_view_t;

  logic [DATA_W-1:0] words [CAPACITY];
  int                fill;
  int                pos;
  list_view_t        due_views [$];

  // Open a hole at slot p and place w there.
  function automatic void put_word(int p, logic [DATA_W-1:0] w);
    for (int i = fill; i > p; i--) words[i] = words[i-1];
    words[p] = w;
    fill++;
  endfunction

  // Close the gap left by slot p.
  function automatic void drop_word(int p);
    for (int i = p; i + 1 < fill; i++) words[i] = words[i+1];
    fill--;
  endfunction

  function automatic list_view_t step_list(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] w,
                                           logic [IDX_W-1:0] idx);
    list_view_t v;
    logic       cur;
    logic       full;
    v    = '0;
    cur  = (pos < fill);
    full = (fill >= CAPACITY);
    v.status = ST_OK;
    case (op)
      F_START: pos = 0;
      F_END: pos = (fill == 0) ? 0 : fill - 1;
      F_LAST: pos = CAPACITY - 1;
      F_ADVANCE: begin
        if (!cur) v.status = ST_NOCUR;
        else if (pos < CAPACITY - 1) pos++;
      end
      F_RETREAT: if (pos > 0) pos--;
      F_INSERT: begin
        if (full) v.status = ST_FULL;
        else if (!cur) begin
          put_word(0, w);
          pos = 0;
        end else put_word(pos, w);
      end
      F_ATTACH: begin
        if (full) v.status = ST_FULL;
        else if (fill == 0) begin
          put_word(0, w);
          pos = 0;
        end else if (!cur) begin
          pos = fill;
          put_word(fill, w);
        end else begin
          put_word(pos + 1, w);
          pos++;
        end
      end
      F_REMOVE: begin
        if (!cur) v.status = ST_NOCUR;
        else drop_word(pos);
      end
      F_INSERT_FRONT: begin
        if (full) v.status = ST_FULL;
        else begin
          put_word(0, w);
          pos = 0;
        end
      end
      F_ATTACH_BACK: begin
        // Cursor lands on the new count, so nothing is current afterwards
        if (full) v.status = ST_FULL;
        else begin
          put_word(fill, w);
          pos = fill;
        end
      end
      F_REMOVE_FRONT: begin
        if (fill == 0) v.status = ST_NOCUR;
        else begin
          pos = 0;
          drop_word(0);
        end
      end
      F_READ: begin
        if (int'(idx) < fill) v.read_value = words[idx];
        else v.status = ST_RANGE;
      end
      default: ;
    endcase
    if (pos < fill && pos < CAPACITY) begin
      v.has_current   = 1'b1;
      v.current_value = words[pos];
    end
    v.entry_count = CW'(fill);
    return v;
  endfunction

  function automatic int field_differs(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    list_view_t want;
    if (!rst_n) begin
      fill       = 0;
      pos        = 0;
      mismatches = 0;
      due_views.delete();
    end else begin
      if (in_valid && in_ready)
        due_views.push_back(step_list(in_func, in_entry_value, in_read_index));
      if (out_valid && out_ready) begin
        if (due_views.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = due_views.pop_front();
          mismatches += field_differs("status", DATA_W'(want.status), DATA_W'(out_status));
          mismatches += field_differs("has_current", DATA_W'(want.has_current),
                                      DATA_W'(out_has_current));
          mismatches += field_differs("current_value", want.current_value, out_current_value);
          mismatches += field_differs("entry_count", DATA_W'(want.entry_count),
                                      DATA_W'(out_entry_count));
          mismatches += field_differs("read_value", want.read_value, out_read_value);
        end
      end
    end
    beats_due = due_views.size();
  end

endmodule

@@ tb/sv/cursor_array_sequence_unit_tb.sv @@
// Top of the cursor list unit testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module cursor_array_sequence_unit_tb;
  import casu_pkg::*;

  // Codes the package leaves out: status query and the spare range that acts like it
  localparam logic [FUNC_W-1:0] F_QUERY    = 4'd12;
  localparam logic [FUNC_W-1:0] F_SPARE_LO = 4'd13;
  localparam logic [FUNC_W-1:0] F_SPARE_HI = 4'd15;

  localparam int RANDOM_ITEMS = 1000;
  // Margin for the worst shift sweep over a full list on top of the base latency
  localparam int DRAIN_CYCLES = 3 * CAPACITY + 20;

  localparam int MODE_GROW   = 0;
  localparam int MODE_MIXED  = 1;
  localparam int MODE_SHRINK = 2;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic [DATA_W-1:0] in_entry_value = '0;
  logic [IDX_W-1:0]  in_read_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic              out_has_current;
  logic [DATA_W-1:0] out_current_value;
  logic [CW-1:0]     out_entry_count;
  logic [DATA_W-1:0] out_read_value;

  // High during the stretch where neither side idles
  logic quiet = 1'b0;
  int   mismatches;
  int   beats_due;

  always #1 clk = ~clk;

  cursor_array_sequence_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_entry_value    (in_entry_value),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_has_current   (out_has_current),
    .out_current_value (out_current_value),
    .out_entry_count   (out_entry_count),
    .out_read_value    (out_read_value)
  );

  cursor_list_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_entry_value    (in_entry_value),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_has_current   (out_has_current),
    .out_current_value (out_current_value),
    .out_entry_count   (out_entry_count),
    .out_read_value    (out_read_value),
    .mismatches        (mismatches),
    .beats_due         (beats_due)
  );

  // Stall the result side at random with a ten percent chance, except in the quiet stretch.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 10);
  end

  // Offer one beat, idling at random first, and hold it until the block takes it.
  // Returns at the edge where the beat was accepted, with in_valid still high.
  task automatic offer_beat(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] w,
                            logic [IDX_W-1:0] idx);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= op;
    in_entry_value <= w;
    in_read_index  <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly fully random words, with the all-zero and all-one words mixed in.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Pick an operation; the mode tilts the mix toward growing or shrinking the list
  // so that both the full and the empty corners are visited often.
  function automatic logic [FUNC_W-1:0] pick_op(int mode);
    logic [FUNC_W-1:0] grow_ops [4];
    int                r;
    int                grow_pct;
    int                shrink_pct;
    grow_ops   = '{F_INSERT, F_ATTACH, F_INSERT_FRONT, F_ATTACH_BACK};
    r          = $urandom_range(99);
    grow_pct   = (mode == MODE_GROW) ? 50 : (mode == MODE_SHRINK) ? 10 : 30;
    shrink_pct = (mode == MODE_GROW) ? 10 : (mode == MODE_SHRINK) ? 50 : 30;
    if (r < grow_pct) return grow_ops[$urandom_range(3)];
    r -= grow_pct;
    if (r < shrink_pct) return $urandom_range(1) ? F_REMOVE : F_REMOVE_FRONT;
    r -= shrink_pct;
    if (r < 20) return FUNC_W'($urandom_range(F_START, F_RETREAT));
    if (r < 35) return F_READ;
    return FUNC_W'($urandom_range(F_QUERY, F_SPARE_HI));
  endfunction

  initial begin
    int mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: every corner on an empty list first, then a short build-up
    offer_beat(F_QUERY, '0, '0);
    offer_beat(F_REMOVE, '0, '0);              // no current item
    offer_beat(F_REMOVE_FRONT, '0, '0);        // empty list
    offer_beat(F_ADVANCE, '0, '0);             // no current item
    offer_beat(F_RETREAT, '0, '0);             // cursor already at zero
    offer_beat(F_END, '0, '0);                 // end of an empty list
    offer_beat(F_READ, '1, '0);                // read past the count
    offer_beat(F_ATTACH, '1, '1);              // attach on an empty list
    offer_beat(F_INSERT, '0, '0);              // insert before the current entry
    offer_beat(F_ATTACH_BACK, {32{2'b10}}, '0);  // leaves no current item
    offer_beat(F_INSERT, pick_word(), '0);     // insert without current goes to the front
    offer_beat(F_INSERT_FRONT, {32{2'b01}}, '0);
    offer_beat(F_END, '0, '0);
    offer_beat(F_ADVANCE, '0, '0);             // step off the last entry
    offer_beat(F_ATTACH, pick_word(), '0);     // attach without current appends
    offer_beat(F_LAST, '0, '0);                // top slot regardless of count
    offer_beat(F_ADVANCE, '0, '0);
    offer_beat(F_READ, '0, '1);                // highest index, out of range
    offer_beat(F_READ, '0, IDX_W'(2));
    offer_beat(F_START, '0, '0);
    offer_beat(F_REMOVE, '0, '0);
    offer_beat(F_RETREAT, '0, '0);
    offer_beat(F_SPARE_LO, '1, '1);
    offer_beat(F_SPARE_LO + 4'd1, '0, '0);
    offer_beat(F_SPARE_HI, '1, '1);
    offer_beat(F_REMOVE_FRONT, '0, '0);

    // Random part: alternate grow, mixed and shrink phases of a hundred beats
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 500) quiet <= 1'b1;
      if (n == 700) quiet <= 1'b0;
      case ((n / 100) % 4)
        0: mode = MODE_GROW;
        2: mode = MODE_SHRINK;
        default: mode = MODE_MIXED;
      endcase
      offer_beat(pick_op(mode), pick_word(), IDX_W'($urandom()));
    end
    in_valid <= 1'b0;

    // Drain: sample the count of outstanding results away from the active edge
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
